// File: hw/rtl/id_number_validator_macros.svh
// Assertion macros for the identity number checker.
// Expects clk and arst_n in the scope of each use.
`ifndef ID_NUMBER_VALIDATOR_MACROS_SVH
`define ID_NUMBER_VALIDATOR_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define IDV_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("id checker: same-cycle rule failed");

// Next-cycle implication.
`define IDV_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("id checker: next-cycle rule failed");

`else

`define IDV_ASSERT_NOW(label, ante, cons)
`define IDV_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/idval_pkg.sv
// Types, constants and small helper functions for the identity number checker.
// No dependencies.
`timescale 1ns / 1ps

package idval_pkg;

	localparam int unsigned NUM_CHARS    = 18;
	localparam int unsigned POS_W        = 5;
	localparam int unsigned YEAR_W       = 14;
	localparam int unsigned MD_W         = 7;
	localparam int unsigned CFG_MONTH_W  = 4;
	localparam int unsigned CFG_DAY_W    = 5;
	localparam int unsigned CFG_IDX_W    = 2;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(NUM_CHARS - 1);

	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;
	localparam logic [7:0] ASCII_X    = 8'h58;

	localparam logic [3:0] CHECK_X_VAL = 4'd10;

	localparam logic [YEAR_W-1:0] RST_YEAR  = YEAR_W'(2019);
	localparam logic [CFG_MONTH_W-1:0] RST_MONTH = CFG_MONTH_W'(1);
	localparam logic [CFG_DAY_W-1:0] RST_DAY = CFG_DAY_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_YEAR  = 2'd0,
		REG_MONTH = 2'd1,
		REG_DAY   = 2'd2
	} cfg_reg_t;

	// lowest bit first: format_ok, birth_date_ok, check_ok, id_valid
	typedef struct packed {
		logic id_valid;
		logic check_ok;
		logic birth_date_ok;
		logic format_ok;
	} result_t;

	// weight of position p is 2^(17-p) mod 11
	function automatic logic [3:0] pos_weight(input logic [POS_W-1:0] pos);
		logic [3:0] w;
		case (pos)
			5'd0:    w = 4'd7;
			5'd1:    w = 4'd9;
			5'd2:    w = 4'd10;
			5'd3:    w = 4'd5;
			5'd4:    w = 4'd8;
			5'd5:    w = 4'd4;
			5'd6:    w = 4'd2;
			5'd7:    w = 4'd1;
			5'd8:    w = 4'd6;
			5'd9:    w = 4'd3;
			5'd10:   w = 4'd7;
			5'd11:   w = 4'd9;
			5'd12:   w = 4'd10;
			5'd13:   w = 4'd5;
			5'd14:   w = 4'd8;
			5'd15:   w = 4'd4;
			5'd16:   w = 4'd2;
			default: w = 4'd0;
		endcase
		return w;
	endfunction

	// v mod 11 for v below 128: reciprocal estimate, then one correction
	function automatic logic [3:0] mod11(input logic [6:0] v);
		logic [13:0] prod;
		logic [3:0]  q;
		logic [7:0]  r;
		prod = 14'(v) * 14'd93;
		q = prod[13:10];
		r = 8'(v) - 8'(q) * 8'd11;
		if (r >= 8'd11) begin
			r = r - 8'd11;
		end
		return r[3:0];
	endfunction

endpackage

// File: hw/rtl/id_number_validator.sv
// Identity number checker top level: 18 ASCII characters in, one verdict out.
// Depends on idval_pkg and id_number_validator_macros.svh.
//
//   channel  | direction | payload
//   ---------+-----------+-----------------------------------------------------
//   s_*      | in        | tdata[7:0] char_code
//   m_*      | out       | tdata[3:0] format_ok, birth_date_ok, check_ok, id_valid
//   cfg_*    | in        | cfg_index: 0 year, 1 month, 2 day; cfg_data value
//
// One character per clock sustained, unless the 18th waits on an untaken verdict.
// A character is registered, then its sum/date update (or the final verdict) is a
// single pass of logic into the state and result registers.
// arst_n clears position, sum and flags and loads the default current date.
// A stalled m side holds the verdict; the input register keeps taking items
// until a second verdict would be needed.
`timescale 1ns / 1ps

`include "id_number_validator_macros.svh"

module id_number_validator
	import idval_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,      // [7:0] char_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,      // [0] format_ok [1] birth_date_ok [2] check_ok
	                                  // [3] id_valid [7:4] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [13:0] cfg_data
);

	logic [YEAR_W-1:0]      cur_year_q;
	logic [CFG_MONTH_W-1:0] cur_month_q;
	logic [CFG_DAY_W-1:0]   cur_day_q;

	logic              valid_s1;
	logic [7:0]        char_s1;

	logic [POS_W-1:0]  pos_q;
	logic [3:0]        sum_q;
	logic              fmt_err_q;
	logic [YEAR_W-1:0] year_q;
	logic [MD_W-1:0]   month_q;
	logic [MD_W-1:0]   day_q;

	logic              out_valid_q;
	result_t           out_q;

	logic              is_digit;
	logic [3:0]        digit;
	logic              is_last;
	logic              out_free;
	logic              fire_s1;
	logic [6:0]        prod;
	logic [4:0]        sum_ext;
	logic [3:0]        sum_next;
	logic [YEAR_W+3:0] year_x10;
	logic [MD_W+3:0]   month_x10;
	logic [MD_W+3:0]   day_x10;
	logic [4:0]        day_limit;
	logic              date_ok;
	logic [3:0]        expect_val;
	logic [3:0]        check_val;
	result_t           res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_year_q  <= RST_YEAR;
			cur_month_q <= RST_MONTH;
			cur_day_q   <= RST_DAY;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_YEAR:  cur_year_q  <= cfg_data[YEAR_W-1:0];
				REG_MONTH: cur_month_q <= cfg_data[CFG_MONTH_W-1:0];
				REG_DAY:   cur_day_q   <= cfg_data[CFG_DAY_W-1:0];
				default: ;
			endcase
		end
	end

	// the stage stalls only on the last character while a verdict is still waiting
	assign is_last  = (pos_q == LAST_POS);
	assign out_free = !out_valid_q || m_tready;
	assign fire_s1  = valid_s1 && (!is_last || out_free);
	assign s_tready = !valid_s1 || fire_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
		end
	end

	assign is_digit = (char_s1 >= ASCII_ZERO) && (char_s1 <= ASCII_NINE);
	assign digit    = is_digit ? 4'(char_s1 - ASCII_ZERO) : 4'd0;

	assign prod     = 7'(digit) * 7'(pos_weight(pos_q));
	assign sum_ext  = 5'(sum_q) + 5'(mod11(prod));
	assign sum_next = (sum_ext >= 5'd11) ? 4'(sum_ext - 5'd11) : sum_ext[3:0];

	assign year_x10  = {year_q, 3'b000} + {3'b000, year_q, 1'b0} + 18'(digit);
	assign month_x10 = {month_q, 3'b000} + {3'b000, month_q, 1'b0} + 10'(digit);
	assign day_x10   = {day_q, 3'b000} + {3'b000, day_q, 1'b0} + 10'(digit);

	always_comb begin
		case (month_q)
			7'd2:                      day_limit = (year_q[1:0] == 2'b00) ? 5'd29 : 5'd28;
			7'd4, 7'd6, 7'd9, 7'd11:   day_limit = 5'd30;
			default:                   day_limit = 5'd31;
		endcase
		date_ok = (month_q >= 7'd1) && (month_q <= 7'd12)
			&& (day_q >= 7'd1) && (day_q <= 7'(day_limit))
			&& (year_q <= cur_year_q);
		if (year_q == cur_year_q) begin
			if (month_q > 7'(cur_month_q)) begin
				date_ok = 1'b0;
			end else if ((month_q == 7'(cur_month_q)) && (day_q > 7'(cur_day_q))) begin
				date_ok = 1'b0;
			end
		end
	end

	assign expect_val = (sum_q <= 4'd1) ? 4'(4'd1 - sum_q) : 4'(4'd12 - sum_q);
	assign check_val  = is_digit ? digit : CHECK_X_VAL;

	always_comb begin
		res.format_ok     = !fmt_err_q && (is_digit || (char_s1 == ASCII_X));
		res.birth_date_ok = res.format_ok && date_ok;
		res.check_ok      = res.format_ok && (check_val == expect_val);
		res.id_valid      = res.birth_date_ok && res.check_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			sum_q     <= '0;
			fmt_err_q <= 1'b0;
			year_q    <= '0;
			month_q   <= '0;
			day_q     <= '0;
		end else if (fire_s1) begin
			if (is_last) begin
				// start over for the next number
				pos_q     <= '0;
				sum_q     <= '0;
				fmt_err_q <= 1'b0;
				year_q    <= '0;
				month_q   <= '0;
				day_q     <= '0;
			end else begin
				pos_q <= pos_q + 5'd1;
				sum_q <= sum_next;
				if (!is_digit) begin
					fmt_err_q <= 1'b1;
				end
				if ((pos_q >= 5'd6) && (pos_q <= 5'd9)) begin
					year_q <= year_x10[YEAR_W-1:0];
				end else if ((pos_q == 5'd10) || (pos_q == 5'd11)) begin
					month_q <= month_x10[MD_W-1:0];
				end else if ((pos_q == 5'd12) || (pos_q == 5'd13)) begin
					day_q <= day_x10[MD_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && is_last) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && is_last) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0000, out_q};

	`IDV_ASSERT_NOW(a_pos_range, 1'b1, pos_q <= LAST_POS)
	`IDV_ASSERT_NEXT(a_wrap, fire_s1 && is_last, pos_q == '0 && out_valid_q)
	`IDV_ASSERT_NEXT(a_s1_hold, valid_s1 && !fire_s1, valid_s1 && $stable(char_s1))
	`IDV_ASSERT_NOW(a_verdict, out_valid_q,
		out_q.id_valid == (out_q.birth_date_ok && out_q.check_ok))
	`IDV_ASSERT_NOW(a_fmt_gate, out_valid_q && !out_q.format_ok,
		!out_q.birth_date_ok && !out_q.check_ok)

endmodule

// File: sim/tb_id_number_validator.sv
`timescale 1ns / 1ps
// Self-checking bench for id_number_validator: streams 18-character identity numbers,
// predicts each verdict locally and compares it field by field on the result stream.
// Depends on idval_pkg and the RTL in hw/rtl.

module tb_id_number_validator
	import idval_pkg::*;
();

	localparam int ID_LEN = 18;
	localparam logic [1:0] REG_NONE = 2'd3;       // decodes to no register
	localparam logic [7:0] ASCII_LOWER_X = 8'h78;

	typedef logic [7:0] id_str_t [ID_LEN];
	typedef enum {RX_OPEN, RX_HALF, RX_SLOW, RX_MOSTLY} rx_mode_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;      // [7:0] char_code
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;      // [0] format_ok [1] birth_date_ok [2] check_ok [3] id_valid
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [13:0] cfg_data;

	id_number_validator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// local copy of the checker state and today's date
	int pos_cnt, wsum, birth_yr, birth_mo, birth_dy;
	bit bad_char;
	int today_year = 2019, today_month = 1, today_day = 1;
	result_t verdict_q [$];

	int errors = 0;
	int burst_left = 0;
	int gap_max = 6;
	int stall_left = 0;
	bit stall_req = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// weight of position p is 2^(17-p) mod 11
	function automatic int weight_of(input int p);
		int w;
		w = 1;
		for (int i = p; i < ID_LEN - 1; i++) w = (w * 2) % 11;
		return w;
	endfunction

	function automatic bit birth_date_legal(input int y, input int m, input int d);
		int last;
		if (m < 1 || m > 12) return 1'b0;
		case (m)
			2:          last = (y % 4 == 0) ? 29 : 28;
			4, 6, 9, 11: last = 30;
			default:    last = 31;
		endcase
		if (d < 1 || d > last) return 1'b0;
		if (y > today_year) return 1'b0;
		if (y == today_year && (m > today_month || (m == today_month && d > today_day)))
			return 1'b0;
		return 1'b1;
	endfunction

	// advance the local state by one accepted character
	task automatic predict_char(input logic [7:0] c);
		bit dig;
		int v;
		result_t r;
		dig = (c >= ASCII_ZERO && c <= ASCII_NINE);
		v = dig ? int'(c) - int'(ASCII_ZERO) : 0;
		if (pos_cnt < ID_LEN - 1) begin
			if (!dig) bad_char = 1'b1;
			wsum = (wsum + v * weight_of(pos_cnt)) % 11;
			if (pos_cnt >= 6 && pos_cnt <= 9)
				birth_yr = (birth_yr * 10 + v) & 14'h3FFF;
			else if (pos_cnt == 10 || pos_cnt == 11)
				birth_mo = (birth_mo * 10 + v) & 7'h7F;
			else if (pos_cnt == 12 || pos_cnt == 13)
				birth_dy = (birth_dy * 10 + v) & 7'h7F;
			pos_cnt++;
		end else begin
			r.format_ok     = !bad_char && (dig || c == ASCII_X);
			r.birth_date_ok = r.format_ok && birth_date_legal(birth_yr, birth_mo, birth_dy);
			r.check_ok      = r.format_ok && ((dig ? v : 10) == (12 - wsum) % 11);
			r.id_valid      = r.format_ok && r.birth_date_ok && r.check_ok;
			verdict_q.push_back(r);
			pos_cnt = 0;
			wsum = 0;
			bad_char = 1'b0;
			birth_yr = 0;
			birth_mo = 0;
			birth_dy = 0;
		end
	endtask

	function automatic logic [7:0] digit_char(input int v);
		return ASCII_ZERO + 8'(v);
	endfunction

	function automatic logic [7:0] check_char(input int v);
		return (v == 10) ? ASCII_X : digit_char(v);
	endfunction

	// check value that the first 17 digits call for
	function automatic int check_value(input id_str_t s);
		int sum;
		sum = 0;
		for (int i = 0; i < ID_LEN - 1; i++)
			sum = (sum + (int'(s[i]) - int'(ASCII_ZERO)) * weight_of(i)) % 11;
		return (12 - sum) % 11;
	endfunction

	// well-formed number; check >= 0 forces that check value via the last two serial digits
	function automatic id_str_t make_id(input int y, input int m, input int d, input int check);
		id_str_t s;
		bit found;
		for (int i = 0; i < ID_LEN - 1; i++) s[i] = digit_char($urandom_range(9, 0));
		s[6]  = digit_char(y / 1000 % 10);
		s[7]  = digit_char(y / 100 % 10);
		s[8]  = digit_char(y / 10 % 10);
		s[9]  = digit_char(y % 10);
		s[10] = digit_char(m / 10 % 10);
		s[11] = digit_char(m % 10);
		s[12] = digit_char(d / 10 % 10);
		s[13] = digit_char(d % 10);
		s[17] = check_char(check_value(s));
		if (check >= 0) begin
			found = 1'b0;
			for (int a = 0; a < 10 && !found; a++)
				for (int b = 0; b < 10 && !found; b++) begin
					s[15] = digit_char(a);
					s[16] = digit_char(b);
					found = (check_value(s) == check);
				end
			s[17] = check_char(check);
		end
		return s;
	endfunction

	function automatic id_str_t random_id();
		id_str_t s;
		int y, m, d, kind;
		kind = $urandom_range(99, 0);
		if (kind >= 85) begin
			// raw noise, mostly digits so some pass the format check
			for (int i = 0; i < ID_LEN; i++)
				s[i] = ($urandom_range(3, 0) != 0) ? digit_char($urandom_range(9, 0))
				                                   : 8'($urandom);
			return s;
		end
		case ($urandom_range(3, 0))
			0:       y = today_year;
			1:       y = today_year + 1;
			2:       y = today_year - 1;
			default: y = $urandom_range(2099, 1900);
		endcase
		if (y > 9999) y = 9999;
		if (y < 0) y = 0;
		m = ($urandom_range(9, 0) != 0) ? $urandom_range(12, 1) : $urandom_range(99, 0);
		if ($urandom_range(2, 0) == 0) m = today_month;
		d = ($urandom_range(9, 0) != 0) ? $urandom_range(31, 1) : $urandom_range(99, 0);
		if ($urandom_range(2, 0) == 0) d = today_day + 1 - $urandom_range(2, 0);
		if (d < 0) d = 0;
		if (kind < 60)
			s = make_id(y, m, d, -1);
		else if (kind < 65)
			s = make_id(y, m, d, 10);
		else if (kind < 70)
			s = make_id(y, m, d, 0);
		else begin
			s = make_id(y, m, d, -1);
			if (kind < 78)
				s[17] = check_char((check_value(s) + $urandom_range(10, 1)) % 11);
			else
				s[$urandom_range(ID_LEN - 1, 0)] = 8'($urandom);
		end
		return s;
	endfunction

	task automatic send_char(input logic [7:0] c);
		if (burst_left == 0) begin
			if (gap_max > 0) begin
				s_tvalid <= 1'b0;
				s_tdata <= 8'($urandom);
				repeat ($urandom_range(gap_max, 1)) @(posedge clk);
			end
			burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(200, 50)
			                                        : $urandom_range(30, 1);
		end
		s_tvalid <= 1'b1;
		s_tdata <= c;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_char(c);
		burst_left--;
	endtask

	task automatic send_id(input id_str_t s);
		for (int i = 0; i < ID_LEN; i++) send_char(s[i]);
	endtask

	// drain all verdicts, then let the pipeline settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_YEAR:  today_year = val;
			REG_MONTH: today_month = val[3:0];
			REG_DAY:   today_day = val[4:0];
			default:   ;
		endcase
	endtask

	task automatic set_today(input int y, input int m, input int d, input bit stray);
		write_reg(REG_YEAR, 14'(y));
		write_reg(REG_MONTH, 14'(m));
		write_reg(REG_DAY, 14'(d));
		if (stray) write_reg(REG_NONE, 14'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic cmp_field(input string name, input logic [3:0] want, input logic [3:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h got %h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_verdict(input logic [7:0] word);
		result_t want;
		result_t got;
		if (verdict_q.size() == 0) begin
			$display("%0t: verdict expected none got %h", $time, word);
			errors++;
		end else begin
			want = verdict_q.pop_front();
			got = word[3:0];
			cmp_field("format_ok", want.format_ok, got.format_ok);
			cmp_field("birth_date_ok", want.birth_date_ok, got.birth_date_ok);
			cmp_field("check_ok", want.check_ok, got.check_ok);
			cmp_field("id_valid", want.id_valid, got.id_valid);
			cmp_field("tdata pad", 4'h0, word[7:4]);
		end
	endtask

	// result side: check each item, stall on a changing pattern plus one long hold
	initial begin
		rx_mode_t mode;
		int mode_left;
		mode = RX_OPEN;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid === 1'b1 && m_tready === 1'b1) check_verdict(m_tdata);
			if (stall_req) begin
				stall_req = 1'b0;
				stall_left = 400;
			end
			if (mode_left == 0) begin
				mode = rx_mode_t'($urandom_range(3, 0));
				mode_left = $urandom_range(300, 20);
			end
			mode_left--;
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else begin
				case (mode)
					RX_OPEN:  m_tready <= 1'b1;
					RX_HALF:  m_tready <= ($urandom_range(1, 0) == 1);
					RX_SLOW:  m_tready <= ($urandom_range(3, 0) == 0);
					default:  m_tready <= ($urandom_range(7, 0) != 0);
				endcase
			end
		end
	end

	task automatic test_format();
		id_str_t s;
		send_id(make_id(1985, 7, 14, -1));
		// non-digits at the digit range edges and at the byte extremes
		s = make_id(1985, 7, 14, -1);
		s[0] = 8'h00;
		s[5] = 8'hFF;
		s[16] = 8'h3A;
		send_id(s);
		s = make_id(1985, 7, 14, -1);
		s[8] = 8'h2F;
		send_id(s);
		s = make_id(1985, 7, 14, 10);
		s[17] = ASCII_LOWER_X;
		send_id(s);
		s = make_id(1985, 7, 14, -1);
		s[17] = 8'hFF;
		send_id(s);
		s[17] = 8'h59;
		send_id(s);
	endtask

	task automatic test_check_char();
		id_str_t s;
		send_id(make_id(1972, 11, 3, 10));
		send_id(make_id(1972, 11, 3, 0));
		s = make_id(1972, 11, 3, -1);
		s[17] = check_char((check_value(s) + 1) % 11);
		send_id(s);
	endtask

	task automatic test_dates();
		send_id(make_id(1990, 0, 10, -1));
		send_id(make_id(1990, 13, 10, -1));
		send_id(make_id(1990, 12, 31, -1));
		send_id(make_id(1990, 4, 31, -1));
		send_id(make_id(1990, 4, 30, -1));
		send_id(make_id(1990, 1, 0, -1));
		// leap day follows year mod 4 only
		send_id(make_id(2000, 2, 29, -1));
		send_id(make_id(1900, 2, 29, -1));
		send_id(make_id(2001, 2, 29, -1));
		send_id(make_id(2019, 1, 1, -1));
		send_id(make_id(2019, 1, 2, -1));
		send_id(make_id(2019, 2, 1, -1));
		send_id(make_id(2020, 1, 1, -1));
	endtask

	task automatic test_config_extremes();
		wait_idle();
		set_today(9999, 12, 31, 1'b0);
		send_id(make_id(9999, 12, 31, -1));
		wait_idle();
		set_today(0, 1, 1, 1'b1);
		send_id(make_id(0, 1, 1, -1));
		send_id(make_id(0, 1, 2, -1));
		// all-ones data: month and day keep only their low bits
		wait_idle();
		set_today(16383, 16383, 16383, 1'b0);
		send_id(make_id(9999, 12, 31, -1));
		wait_idle();
		set_today(2000, 0, 0, 1'b0);
		send_id(make_id(2000, 1, 1, -1));
	endtask

	// hold the result side off while the sender keeps offering items
	task automatic test_backpressure();
		wait_idle();
		set_today(2019, 6, 15, 1'b0);
		stall_req = 1'b1;
		gap_max = 0;
		for (int k = 0; k < 6; k++) send_id(random_id());
		gap_max = 6;
	endtask

	task automatic test_random();
		int y, m, d;
		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			case ($urandom_range(9, 0))
				0:       y = 0;
				1:       y = 16383;
				2:       y = 9999;
				default: y = $urandom_range(2100, 1900);
			endcase
			m = ($urandom_range(9, 0) == 0) ? $urandom_range(15, 0) : $urandom_range(12, 1);
			d = ($urandom_range(9, 0) == 0) ? $urandom_range(31, 0) : $urandom_range(31, 1);
			set_today(y, m, d, ph == 2);
			for (int k = 0; k < 14; k++) send_id(random_id());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		m_tready <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_YEAR;
		cfg_data <= 14'h0;
		pos_cnt = 0;
		wsum = 0;
		bad_char = 1'b0;
		birth_yr = 0;
		birth_mo = 0;
		birth_dy = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_format();
		test_check_char();
		test_dates();
		test_config_extremes();
		test_backpressure();
		test_random();

		wait_idle();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
